// ===== sv/sorted_priority_queue_unit_macros.svh =====
// assertion macros used by the bind checker spq_checker
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// checked only out of reset
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
package spq_pkg;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic               action;
        logic signed [31:0] value_in;
        logic signed [31:0] priority_in;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [4:0]         occupancy;
    } rsp_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_state_t;

    typedef struct packed {
        logic load_item;
        logic execute;
    } cmd_t;

endpackage

// ===== sv/spq_datapath.sv =====
module spq_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  spq_pkg::cmd_t cmd,
    input  spq_pkg::req_t req_data,
    output spq_pkg::rsp_t rsp_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_pkg::req_t      item_reg;
    spq_pkg::rsp_t      rsp_reg;
    spq_pkg::rsp_t      rsp_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W+4:0]   count_ext;

    logic signed [31:0] val_reg  [CAPACITY];
    logic signed [31:0] pri_reg  [CAPACITY];
    logic signed [31:0] val_next [CAPACITY];
    logic signed [31:0] pri_next [CAPACITY];

    logic [CAPACITY-1:0] entry_le;
    logic                is_full;
    logic                is_empty;
    logic                do_insert;
    logic                do_remove;

    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign do_insert = (item_reg.action == spq_pkg::ACT_INSERT) && !is_full;
    assign do_remove = (item_reg.action == spq_pkg::ACT_REMOVE) && !is_empty;

    // each stored entry compares itself with the incoming priority
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entry_le[i] = (CNT_W'(i) < count_reg) && (pri_reg[i] <= item_reg.priority_in);
        end
    end

    // shift right behind the insert point, or shift left on remove
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
            if (do_insert && !entry_le[i])
            begin
                if (i == 0)
                begin
                    val_next[i] = item_reg.value_in;
                    pri_next[i] = item_reg.priority_in;
                end
                else if (entry_le[i-1])
                begin
                    val_next[i] = item_reg.value_in;
                    pri_next[i] = item_reg.priority_in;
                end
                else
                begin
                    val_next[i] = val_reg[i-1];
                    pri_next[i] = pri_reg[i-1];
                end
            end
            else if (do_remove && (i < CAPACITY - 1))
            begin
                val_next[i] = val_reg[i+1];
                pri_next[i] = pri_reg[i+1];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        rsp_next   = '0;
        if (item_reg.action == spq_pkg::ACT_INSERT)
        begin
            if (is_full)
            begin
                rsp_next.status = spq_pkg::ST_FULL;
            end
            else
            begin
                rsp_next.status = spq_pkg::ST_INSERTED;
                count_next      = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (is_empty)
            begin
                rsp_next.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                rsp_next.status    = spq_pkg::ST_REMOVED;
                rsp_next.value_out = val_reg[0];
                count_next         = count_reg - CNT_W'(1);
            end
        end
        count_ext          = (CNT_W + 5)'(count_next);
        rsp_next.occupancy = count_ext[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req_data;
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < CAPACITY; i++)
            begin
                val_reg[i] <= val_next[i];
                pri_reg[i] <= pri_next[i];
            end
        end
    end

    assign rsp_data = rsp_reg;

endmodule

// ===== sv/spq_ctrl.sv =====
module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output spq_pkg::cmd_t cmd
);

    spq_pkg::fsm_state_t state_reg;
    spq_pkg::fsm_state_t state_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::FSM_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            spq_pkg::FSM_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = spq_pkg::FSM_EXEC;
                end
            end
            spq_pkg::FSM_EXEC:
            begin
                // output register free, or its transfer happens now
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.execute    = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = spq_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::FSM_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== sv/sorted_priority_queue_unit.sv =====
// Bounded priority queue of (value, priority) pairs held as a sorted, shifting register
// array of CAPACITY entries. An insert lands after every entry with a priority less than
// or equal to its own, so equal priorities leave in arrival order; a remove returns the
// entry with the smallest signed priority. Each request gives one response: status
// (inserted, removed, remove on empty, insert dropped because full), the removed value
// (0 otherwise) and the occupancy after the operation, reported in 5 bits. A request is
// first captured into an item register; then, in the update step, every entry compares
// against the new priority in parallel and the whole array shifts. A new request is taken
// while the previous response still waits; the update waits only while the output register
// is still full, and no new request is taken until the update is done.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  spq_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output spq_pkg::rsp_t rsp_data
);

    spq_pkg::cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

endmodule

// ===== sv/spq_checker.sv =====
`include "sorted_priority_queue_unit_macros.svh"

module spq_checker #(
    parameter int CAPACITY = 16
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input spq_pkg::rsp_t rsp_data
);

    logic req_fire;
    logic rsp_stalled;
    logic rsp_not_removed;
    logic rsp_full;

    assign req_fire        = req_valid && req_ready;
    assign rsp_stalled     = rsp_valid && !rsp_ready;
    assign rsp_not_removed = rsp_valid && (rsp_data.status != spq_pkg::ST_REMOVED);
    assign rsp_full        = rsp_valid && (rsp_data.status == spq_pkg::ST_FULL);

    `SPQ_ASSERT_ALWAYS(a_no_rsp_after_reset, !rst_n |=> !rsp_valid, "response valid out of reset")

    `SPQ_ASSERT(a_rsp_hold, rsp_stalled |=> rsp_valid && $stable(rsp_data), "response not held")

    `SPQ_ASSERT(a_busy_after_req, req_fire |=> !req_ready, "request taken while busy")

    `SPQ_ASSERT(a_value_zero, rsp_not_removed |-> rsp_data.value_out == 0, "stray value out")

    `SPQ_ASSERT(a_full_occ, rsp_full |-> rsp_data.occupancy == 5'(CAPACITY), "bad full count")

endmodule

bind sorted_priority_queue_unit spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

// ===== verif/spq_response_checker.sv =====
`timescale 1ns / 100ps

module spq_response_checker #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  spq_pkg::req_t req_data,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  spq_pkg::rsp_t rsp_data,
    output int            mismatches,
    output int            outstanding
);

    logic signed [31:0] held_value    [CAPACITY];
    logic signed [31:0] held_priority [CAPACITY];
    int                 held_count = 0;
    spq_pkg::rsp_t      expected_responses [$];
    int                 err_count = 0;
    int                 pending = 0;

    assign mismatches  = err_count;
    assign outstanding = pending;

    // applies one request to the sorted store and returns the response it should give
    function automatic spq_pkg::rsp_t queue_step(input spq_pkg::req_t r);
        spq_pkg::rsp_t res;
        int            pos;
        int            i;
        res = '0;
        if (r.action == spq_pkg::ACT_INSERT)
        begin
            if (held_count >= CAPACITY)
            begin
                res.status = spq_pkg::ST_FULL;
            end
            else
            begin
                pos = 0;
                // equal priorities stay behind, so ties leave in arrival order
                while (pos < held_count && held_priority[pos] <= r.priority_in)
                    pos++;
                for (i = held_count; i > pos; i--)
                begin
                    held_value[i]    = held_value[i - 1];
                    held_priority[i] = held_priority[i - 1];
                end
                held_value[pos]    = r.value_in;
                held_priority[pos] = r.priority_in;
                held_count++;
                res.status = spq_pkg::ST_INSERTED;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                res.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                res.value_out = held_value[0];
                for (i = 1; i < held_count; i++)
                begin
                    held_value[i - 1]    = held_value[i];
                    held_priority[i - 1] = held_priority[i];
                end
                held_count--;
                res.status = spq_pkg::ST_REMOVED;
            end
        end
        res.occupancy = 5'(held_count);
        return res;
    endfunction

    always @(posedge clk)
    begin
        spq_pkg::rsp_t want;
        spq_pkg::rsp_t got;
        if (!rst_n)
        begin
            held_count = 0;
            expected_responses.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                got = rsp_data;
                if (expected_responses.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected response transfer status %0d value %0d occ %0d",
                                 $realtime, got.status, got.value_out, got.occupancy);
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (got.status !== want.status || got.value_out !== want.value_out
                        || got.occupancy !== want.occupancy)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("%0t: expected status %0d value %0d occ %0d, got %0d %0d %0d",
                                     $realtime, want.status, want.value_out, want.occupancy,
                                     got.status, got.value_out, got.occupancy);
                    end
                end
            end
            if (req_valid && req_ready)
                expected_responses.push_back(queue_step(req_data));
        end
        pending = expected_responses.size();
    end

endmodule

// ===== verif/tb_sorted_priority_queue_unit.sv =====
`timescale 1ns / 100ps

module tb_sorted_priority_queue_unit;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_ITEMS   = 200;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    spq_pkg::req_t req_data = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    spq_pkg::rsp_t rsp_data;
    int            mismatches;
    int            outstanding;
    bit            calm = 1'b0;
    int            stall_left = 0;

    always #1 clk = ~clk;

    sorted_priority_queue_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data)
    );

    spq_response_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    // response side backpressure in bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 1)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            rsp_ready  <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 10);
            rsp_ready  <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    function automatic spq_pkg::req_t make_req(input logic act, input logic [31:0] val,
                                               input logic [31:0] pri);
        spq_pkg::req_t r;
        r.action      = act;
        r.value_in    = val;
        r.priority_in = pri;
        return r;
    endfunction

    // small spread gives plenty of ties, extremes hit the compare edges
    function automatic logic [31:0] pick_priority();
        case ($urandom_range(0, 9))
            0:          return 32'h8000_0000;
            1:          return 32'h7fff_ffff;
            2, 3, 4, 5: return 32'($urandom_range(0, 6) - 3);
            default:    return $urandom();
        endcase
    endfunction

    task automatic send_request(input spq_pkg::req_t r, input bit may_idle);
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (!req_ready);
        if (may_idle && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    initial
    begin
        int            insert_pct;
        int            epoch_left;
        int            n;
        spq_pkg::req_t r;

        insert_pct = 50;
        epoch_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // remove on empty, with junk in the ignored fields
        send_request(make_req(spq_pkg::ACT_REMOVE, 32'hffff_ffff, 32'hffff_ffff), 1'b1);
        send_request(make_req(spq_pkg::ACT_INSERT, 32'd1, 32'd0), 1'b1);
        send_request(make_req(spq_pkg::ACT_INSERT, 32'h8000_0000, 32'h7fff_ffff), 1'b1);
        // lands ahead of the front
        send_request(make_req(spq_pkg::ACT_INSERT, 32'h7fff_ffff, 32'h8000_0000), 1'b1);
        // ties at zero and at both extremes
        send_request(make_req(spq_pkg::ACT_INSERT, 32'd2, 32'd0), 1'b1);
        send_request(make_req(spq_pkg::ACT_INSERT, 32'd3, 32'd0), 1'b1);
        send_request(make_req(spq_pkg::ACT_INSERT, 32'd4, 32'h7fff_ffff), 1'b1);
        send_request(make_req(spq_pkg::ACT_INSERT, 32'd5, 32'h8000_0000), 1'b1);
        send_request(make_req(spq_pkg::ACT_INSERT, 32'd6, 32'hffff_ffff), 1'b1);
        send_request(make_req(spq_pkg::ACT_INSERT, 32'd7, 32'd1), 1'b1);
        for (n = 0; n < CAPACITY - 9; n++)
            send_request(make_req(spq_pkg::ACT_INSERT, $urandom(), pick_priority()), 1'b1);
        // store is full now, this one is dropped
        send_request(make_req(spq_pkg::ACT_INSERT, 32'h0000_dead, 32'h8000_0000), 1'b1);
        for (n = 0; n < 5; n++)
            send_request(make_req(spq_pkg::ACT_REMOVE, $urandom(), $urandom()), 1'b1);

        // epochs lean toward insert or remove so the store swings between full and empty
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (epoch_left == 0)
            begin
                epoch_left = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            epoch_left--;
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            r = make_req(($urandom_range(1, 100) <= insert_pct) ? spq_pkg::ACT_INSERT
                                                                : spq_pkg::ACT_REMOVE,
                         $urandom(), pick_priority());
            send_request(r, !calm);
        end
        req_valid <= 1'b0;

        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
